FILE: sv/mlrp_pkg.sv
// Package for the mod list response parser.
// Holds the shared types, phase and sequencer codes, and the byte class helper.
// No dependencies.
package mlrp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;
  localparam logic [2:0] HDR_BYTES = 3'd6;
  localparam logic [31:0] ID_LIMIT = 32'h3b9a_ca00;
  localparam logic [3:0] ID_LEN_MASK = 4'hf;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  typedef enum logic [3:0] {
    PH_HDR, PH_HASH, PH_IDLEN, PH_ID, PH_IDX, PH_SKIP, PH_NLEN, PH_NAME, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SQ_MAIN, SQ_REPLAY, SQ_FLUSH, SQ_STATUS
  } seq_t;

  typedef enum logic [1:0] {
    KIND_COUNT, KIND_HEADER, KIND_CHAR, KIND_STATUS
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_SHORT, ST_TRUNC
  } status_t;

  // one queued input beat, already classified
  typedef struct packed {
    logic [7:0] data;
    logic       eor;
    logic       prt;
  } qentry_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  mod_count;
    logic [7:0]  mod_index;
    logic [31:0] mod_id;
    logic [7:0]  decl_len;
    logic [7:0]  char_pos;
    logic [6:0]  char_value;
    status_t     status;
    logic        last;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_cnt;
    logic [7:0]  mods_left;
    logic [7:0]  cur_mod;
    logic [3:0]  id_len;
    logic [7:0]  name_len;
    logic [7:0]  name_pos;
    logic [2:0]  total_bytes;
    logic [31:0] id_val;
  } pst_t;

  localparam pst_t PST_RESET = '{
    phase: PH_HDR, byte_cnt: 4'd0, mods_left: 8'd0, cur_mod: 8'd0, id_len: 4'd0,
    name_len: 8'd0, name_pos: 8'd0, total_bytes: 3'd0, id_val: 32'd0
  };

  typedef struct packed {
    pst_t       nst;
    logic       emit;
    result_t    res;
    logic       la_we;
    logic [2:0] la_idx;
    logic       rep_go;
    logic [1:0] rep_start;
    logic [2:0] rep_n;
  } feed_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

endpackage

FILE: sv/mlrp_front.sv
// Input side of the parser: takes beats and tags each byte with its class.
// Depends on mlrp_pkg; feeds mlrp_fifo.
module mlrp_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output mlrp_pkg::qentry_t q_entry
);
  import mlrp_pkg::*;

  assign in_tready    = !q_full;
  assign q_push       = in_tvalid && !q_full;
  assign q_entry.data = in_tdata;
  assign q_entry.eor  = in_tlast;
  assign q_entry.prt  = is_printable(in_tdata);

endmodule

FILE: sv/mlrp_fifo.sv
// Short queue between the front and back halves of the parser.
// Depends on mlrp_pkg for the entry type and depth.
module mlrp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlrp_pkg::qentry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output mlrp_pkg::qentry_t head,
  output logic              not_empty
);
  import mlrp_pkg::*;

  qentry_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

FILE: sv/mlrp_back.sv
// Back half of the parser: field decoder, id byte replay sequencer and result register.
// Depends on mlrp_pkg; reads from mlrp_fifo.
module mlrp_back #(
  parameter int unsigned LOOKAHEAD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mlrp_pkg::qentry_t q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mlrp_pkg::result_t out_res
);
  import mlrp_pkg::*;

  localparam int unsigned LA_AW = $clog2(LOOKAHEAD_BYTES);

  seq_t       seq_r, seq_nxt;
  pst_t       st_r, st_nxt;
  logic [7:0] la_r [LOOKAHEAD_BYTES];
  logic       la_we;
  result_t    hold_r, hold_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic [1:0] rep_idx_r, rep_idx_nxt;
  logic [2:0] rep_left_r, rep_left_nxt;
  logic       eor_r, eor_nxt;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       adv, push;
  result_t    push_res;
  logic [7:0] fd_byte;
  logic       fd_prt;
  feed_t      fd;

  function automatic pst_t finish_mod(input pst_t s);
    pst_t       n;
    logic [7:0] ml;
    n           = s;
    ml          = s.mods_left - 8'd1;
    n.cur_mod   = s.cur_mod + 8'd1;
    n.mods_left = ml;
    n.byte_cnt  = 4'd0;
    n.phase     = (ml == 8'd0) ? PH_DONE : PH_HASH;
    return n;
  endfunction

  function automatic result_t mk_status(input pst_t s);
    result_t r;
    r      = '0;
    r.kind = KIND_STATUS;
    r.last = 1'b1;
    if (s.phase == PH_DONE) begin
      r.status = ST_OK;
    end else if ((s.phase == PH_HDR) && (s.total_bytes < HDR_BYTES)) begin
      r.status = ST_SHORT;
    end else begin
      r.status = ST_TRUNC;
    end
    return r;
  endfunction

  // one byte through the field decoder
  function automatic feed_t feed(input pst_t s, input logic [7:0] b, input logic prt,
                                 input logic [7:0] l0, input logic [7:0] l1,
                                 input logic [7:0] l2);
    feed_t       f;
    logic [31:0] v;
    logic [3:0]  bc1;
    logic [7:0]  pos1;
    f   = '0;
    f.nst = s;
    v   = {b, l2, l1, l0};
    bc1 = s.byte_cnt + 4'd1;
    case (s.phase)
      PH_HDR: begin
        if (s.total_bytes < HDR_BYTES) begin
          f.nst.total_bytes = s.total_bytes + 3'd1;
        end else begin
          f.nst.mods_left = b;
          f.nst.cur_mod   = 8'd0;
          f.nst.byte_cnt  = 4'd0;
          f.emit          = 1'b1;
          f.res.kind      = KIND_COUNT;
          f.res.mod_count = b;
          f.nst.phase     = (b != 8'd0) ? PH_HASH : PH_DONE;
        end
      end
      PH_HASH: begin
        f.nst.byte_cnt = bc1;
        if (bc1 >= 4'd4) begin
          f.nst.byte_cnt = 4'd0;
          f.nst.phase    = PH_IDLEN;
        end
      end
      PH_IDLEN: begin
        f.nst.id_len   = b[3:0] & ID_LEN_MASK;
        f.nst.byte_cnt = 4'd0;
        f.nst.phase    = PH_ID;
      end
      PH_ID: begin
        f.la_we        = 1'b1;
        f.la_idx       = {1'b0, s.byte_cnt[1:0]};
        f.nst.byte_cnt = bc1;
        if (bc1 >= 4'd4) begin
          f.nst.id_val = v;
          if (v < ID_LIMIT) begin
            f.nst.phase = PH_IDX;
          end else if (s.id_len < 4'd4) begin
            // short id: the unused id bytes go back through the decoder
            f.rep_go    = 1'b1;
            f.rep_start = s.id_len[1:0];
            f.rep_n     = 3'(4'd4 - s.id_len);
            f.nst.phase = PH_NLEN;
          end else if (s.id_len == 4'd4) begin
            f.nst.phase = PH_NLEN;
          end else begin
            f.nst.byte_cnt = s.id_len - 4'd4;
            f.nst.phase    = PH_SKIP;
          end
        end
      end
      PH_IDX: begin
        f.la_we        = 1'b1;
        f.la_idx       = s.byte_cnt[2:0];
        f.nst.byte_cnt = bc1;
        if (bc1 >= 4'd8) begin
          f.nst.id_val = v;
          f.nst.phase  = PH_NLEN;
        end
      end
      PH_SKIP: begin
        if (s.byte_cnt != 4'd0) begin
          f.nst.byte_cnt = s.byte_cnt - 4'd1;
        end
        if (f.nst.byte_cnt == 4'd0) begin
          f.nst.phase = PH_NLEN;
        end
      end
      PH_NLEN: begin
        f.nst.name_len    = b;
        f.nst.name_pos    = 8'd0;
        f.emit            = 1'b1;
        f.res.kind        = KIND_HEADER;
        f.res.mod_index   = s.cur_mod;
        f.res.mod_id      = s.id_val;
        f.res.decl_len    = b;
        if (b == 8'd0) begin
          f.nst = finish_mod(f.nst);
        end else begin
          f.nst.phase = PH_NAME;
        end
      end
      PH_NAME: begin
        pos1 = s.name_pos;
        if (prt) begin
          f.emit         = 1'b1;
          f.res.kind     = KIND_CHAR;
          f.res.mod_index = s.cur_mod;
          f.res.char_pos = s.name_pos;
          f.res.char_value = b[6:0];
          pos1 = s.name_pos + 8'd1;
        end else if (s.name_pos == 8'd0) begin
          // unprintable first position still takes a slot
          f.emit          = 1'b1;
          f.res.kind      = KIND_CHAR;
          f.res.mod_index = s.cur_mod;
          pos1 = 8'd1;
        end
        f.nst.name_pos = pos1;
        if (pos1 >= s.name_len) begin
          f.nst = finish_mod(f.nst);
        end
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  assign adv = !out_valid_r || out_tready;

  always_comb begin
    if (seq_r == SQ_REPLAY) begin
      fd_byte = la_r[LA_AW'(rep_idx_r)];
      fd_prt  = is_printable(fd_byte);
    end else begin
      fd_byte = q_head.data;
      fd_prt  = q_head.prt;
    end
    fd = feed(st_r, fd_byte, fd_prt, la_r[0], la_r[1], la_r[2]);
  end

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SQ_MAIN: begin
        if (q_valid && adv) begin
          if (fd.rep_go) begin
            seq_nxt = SQ_REPLAY;
          end else if (fd.emit && q_head.eor) begin
            seq_nxt = SQ_STATUS;
          end
        end
      end
      SQ_REPLAY: begin
        if (adv && (rep_left_r == 3'd1)) begin
          seq_nxt = SQ_FLUSH;
        end
      end
      SQ_FLUSH: begin
        if (adv) begin
          seq_nxt = eor_r ? SQ_STATUS : SQ_MAIN;
        end
      end
      SQ_STATUS: begin
        if (adv) begin
          seq_nxt = SQ_MAIN;
        end
      end
      default: seq_nxt = SQ_MAIN;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    q_pop        = 1'b0;
    push         = 1'b0;
    push_res     = '0;
    st_nxt       = st_r;
    la_we        = 1'b0;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    rep_idx_nxt  = rep_idx_r;
    rep_left_nxt = rep_left_r;
    eor_nxt      = eor_r;
    case (seq_r)
      SQ_MAIN: begin
        if (q_valid && adv) begin
          q_pop   = 1'b1;
          st_nxt  = fd.nst;
          la_we   = fd.la_we;
          eor_nxt = q_head.eor;
          if (fd.rep_go) begin
            rep_idx_nxt  = fd.rep_start;
            rep_left_nxt = fd.rep_n;
          end else if (fd.emit) begin
            push          = 1'b1;
            push_res      = fd.res;
            push_res.last = !q_head.eor;
          end else if (q_head.eor) begin
            push     = 1'b1;
            push_res = mk_status(fd.nst);
            st_nxt   = PST_RESET;
          end
        end
      end
      SQ_REPLAY: begin
        if (adv) begin
          st_nxt       = fd.nst;
          rep_idx_nxt  = rep_idx_r + 2'd1;
          rep_left_nxt = rep_left_r - 3'd1;
          // which replay result is the last one is known only at the end
          if (fd.emit) begin
            if (hold_v_r) begin
              push     = 1'b1;
              push_res = hold_r;
            end
            hold_nxt   = fd.res;
            hold_v_nxt = 1'b1;
          end
        end
      end
      SQ_FLUSH: begin
        if (adv) begin
          push          = 1'b1;
          push_res      = hold_r;
          push_res.last = !eor_r;
          hold_v_nxt    = 1'b0;
        end
      end
      SQ_STATUS: begin
        if (adv) begin
          push     = 1'b1;
          push_res = mk_status(st_r);
          st_nxt   = PST_RESET;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_MAIN;
      st_r        <= PST_RESET;
      hold_v_r    <= 1'b0;
      rep_idx_r   <= 2'd0;
      rep_left_r  <= 3'd0;
      eor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      st_r       <= st_nxt;
      hold_v_r   <= hold_v_nxt;
      rep_idx_r  <= rep_idx_nxt;
      rep_left_r <= rep_left_nxt;
      eor_r      <= eor_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (push) begin
      out_res_r <= push_res;
    end
    if (la_we) begin
      la_r[LA_AW'(fd.la_idx)] <= fd_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

`ifndef SYNTHESIS
  a_flush_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_FLUSH) |-> hold_v_r)
    else $error("flush with no held result");

  a_replay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_REPLAY) |-> (rep_left_r != 3'd0))
    else $error("replay state with nothing left to replay");

  a_hold_scope: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> ((seq_r == SQ_REPLAY) || (seq_r == SQ_FLUSH)))
    else $error("held result outside replay");

  a_status_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_res.kind == KIND_STATUS)) |=> (st_r.phase == PH_HDR && seq_r == SQ_MAIN))
    else $error("parser not back at header after end status");

  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_tready))
    else $error("result pushed over an unaccepted one");
`endif

endmodule

FILE: sv/mod_list_response_parser.sv
// Top level of the mod list response parser: front, queue and back halves.
// Depends on mlrp_pkg, mlrp_front, mlrp_fifo and mlrp_back.
//
//  channel | dir | tdata                                   | tuser | tlast
//  in_     | in  | data_byte                               | -     | end_of_response
//  out_    | out | mod_count, mod_index, mod_id,           | kind  | last_result
//          |     | decl_len, char_pos, char_value,         |       |
//          |     | status                                  |       |
//
// One byte per cycle unless the output stalls or the back sequencer is busy; a byte is
// registered into the queue, and its result then into the result register.
// An end byte that also yields a result gives the result, then the end status.
// A short id of length L below 4, valued at or above ID_LIMIT, replays 4 - L id bytes,
// then releases the final replayed result; these steps run in the back sequencer.
// rst_n is synchronous; a 4-entry queue lets input beats land while out_tready is low.
module mod_list_response_parser #(
  parameter int unsigned LOOKAHEAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // mod_count, mod_index, mod_id, decl_len,
                                  // char_pos, char_value, status, zero pad
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);
  import mlrp_pkg::*;

  logic    q_full, q_push, q_pop, q_valid;
  qentry_t q_entry, q_head;
  result_t res;

  mlrp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  mlrp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  mlrp_back #(
    .LOOKAHEAD_BYTES (LOOKAHEAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {7'd0, res.status, res.char_value, res.char_pos, res.decl_len,
                      res.mod_id, res.mod_index, res.mod_count};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
